### src/rmq_pkg.sv
// Shared types and constants for the rotation-matrix-to-quaternion block.
`default_nettype none
package rmq_pkg;

  localparam int IN_W      = 16;  // matrix element width
  localparam int DIAG_W    = 18;  // sum of three elements
  localparam int OUT_W     = 16;  // qx, qy, qz width
  localparam int QW_W      = 15;  // qw width
  localparam int NUM_LANES = 4;

  // Lane order through the square-root pipeline
  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  // Sign of the skew differences; set means the component is negated
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic z_neg;
  } sign_t;

endpackage
`default_nettype wire

### src/rotation_matrix_to_quaternion_top.sv
// Pipeline: three front stages, one stage per root bit of the square root with
// ROOT_W = (RAD_W + FRAC_BITS + 1) / 2, and one output stage.
// Throughput: one request per cycle; the four square roots run as parallel pipelines.
// busy is high only during reset and the cycle after; the receiver cannot stall,
// so out_valid pulses once per request. Synchronous active-low reset clears valid bits.
`default_nettype none
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_r00,
  input  logic signed [15:0] in_r01,
  input  logic signed [15:0] in_r02,
  input  logic signed [15:0] in_r10,
  input  logic signed [15:0] in_r11,
  input  logic signed [15:0] in_r12,
  input  logic signed [15:0] in_r20,
  input  logic signed [15:0] in_r21,
  input  logic signed [15:0] in_r22,
  output logic               out_valid,
  output logic signed [15:0] out_qx,
  output logic signed [15:0] out_qy,
  output logic signed [15:0] out_qz,
  output logic [14:0]        out_qw
);
  import rmq_pkg::*;

  // Clamped radicand 1 + diagonal sum: diagonal sums reach about +/-2^16.6,
  // so it needs the wider of FRAC_BITS+1 and 18 bits.
  localparam int RAD_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  // Square root of radicand << FRAC_BITS, one result bit per stage
  localparam int NW     = RAD_W + FRAC_BITS;
  localparam int ROOT_W = (NW + 1) / 2;
  localparam int LAT    = ROOT_W + 4;

  logic busy_r;
  logic accept;

  logic              f_valid;
  logic [RAD_W-1:0]  f_rad [NUM_LANES];
  sign_t             f_neg;
  logic              s_valid;
  logic [ROOT_W-1:0] s_root [NUM_LANES];
  sign_t             s_neg;

  // busy holds during reset and releases in the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Front: capture, sums of the four trace sign patterns, skew signs, clamp
  rmq_front #(
    .FRAC_BITS (FRAC_BITS),
    .RAD_W     (RAD_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (accept),
    .r00_i   (in_r00),
    .r01_i   (in_r01),
    .r02_i   (in_r02),
    .r10_i   (in_r10),
    .r11_i   (in_r11),
    .r12_i   (in_r12),
    .r20_i   (in_r20),
    .r21_i   (in_r21),
    .r22_i   (in_r22),
    .valid_o (f_valid),
    .rad_o   (f_rad),
    .neg_o   (f_neg)
  );

  // Four floor square roots in lockstep
  rmq_sqrt_pipe #(
    .RAD_W  (RAD_W),
    .SHIFT  (FRAC_BITS),
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .neg_i   (f_neg),
    .valid_o (s_valid),
    .root_o  (s_root),
    .neg_o   (s_neg)
  );

  // Halve, saturate to one, apply signs; output register
  rmq_back #(
    .FRAC_BITS (FRAC_BITS),
    .ROOT_W    (ROOT_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s_valid),
    .root_i  (s_root),
    .neg_i   (s_neg),
    .valid_o (out_valid),
    .qx_o    (out_qx),
    .qy_o    (out_qy),
    .qz_o    (out_qz),
    .qw_o    (out_qw)
  );

`ifndef NO_ASSERTIONS
  // Every accepted request yields a result strobe at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept, LAT) |-> out_valid)
    else $error("no result strobe LAT cycles after a request");

  // Every result strobe answers an accepted request at the head of the pipeline
  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a request LAT cycles earlier");

  // No result right after reset
  a_reset_flush: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  // Block is not busy once reset release has been registered
  a_ready: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy outside reset");
`endif

endmodule
`default_nettype wire

### src/rmq_front.sv
// Front end: input capture, diagonal sums, skew signs and clamped radicands.
`default_nettype none
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int RAD_W     = 18
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  input  logic signed [15:0]         r00_i,
  input  logic signed [15:0]         r01_i,
  input  logic signed [15:0]         r02_i,
  input  logic signed [15:0]         r10_i,
  input  logic signed [15:0]         r11_i,
  input  logic signed [15:0]         r12_i,
  input  logic signed [15:0]         r20_i,
  input  logic signed [15:0]         r21_i,
  input  logic signed [15:0]         r22_i,
  output logic                       valid_o,
  output logic [RAD_W-1:0]           rad_o [rmq_pkg::NUM_LANES],
  output rmq_pkg::sign_t             neg_o
);
  import rmq_pkg::*;

  localparam int SW = RAD_W + 1;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< FRAC_BITS;

  // stage 1: capture
  logic                     v1_r;
  logic signed [IN_W-1:0]   a00_r, a01_r, a02_r, a10_r, a11_r, a12_r, a20_r, a21_r, a22_r;
  // stage 2: sums and signs
  logic                     v2_r;
  logic signed [DIAG_W-1:0] d_r [NUM_LANES];
  logic signed [DIAG_W-1:0] d_nxt [NUM_LANES];
  sign_t                    neg_r, neg_nxt;
  // stage 3: radicands
  logic                     v3_r;
  logic [RAD_W-1:0]         rad_r [NUM_LANES];
  logic [RAD_W-1:0]         rad_nxt [NUM_LANES];

  logic signed [DIAG_W-1:0] e00, e11, e22;
  logic signed [IN_W:0]     dx, dy, dz;

  always_comb begin
    e00 = DIAG_W'(a00_r);
    e11 = DIAG_W'(a11_r);
    e22 = DIAG_W'(a22_r);
    d_nxt[LANE_W] =  e00 + e11 + e22;
    d_nxt[LANE_X] =  e00 - e11 - e22;
    d_nxt[LANE_Y] = -e00 + e11 - e22;
    d_nxt[LANE_Z] = -e00 - e11 + e22;
    dx = (IN_W+1)'(a21_r) - (IN_W+1)'(a12_r);
    dy = (IN_W+1)'(a02_r) - (IN_W+1)'(a20_r);
    dz = (IN_W+1)'(a10_r) - (IN_W+1)'(a01_r);
    neg_nxt.x_neg = dx[IN_W];
    neg_nxt.y_neg = dy[IN_W];
    neg_nxt.z_neg = dz[IN_W];
  end

  // clamp negative radicands to zero
  always_comb begin
    logic signed [SW-1:0] s;
    for (int l = 0; l < NUM_LANES; l++) begin
      s = ONE_S + SW'(d_r[l]);
      rad_nxt[l] = s[SW-1] ? '0 : s[RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a00_r <= r00_i;
    a01_r <= r01_i;
    a02_r <= r02_i;
    a10_r <= r10_i;
    a11_r <= r11_i;
    a12_r <= r12_i;
    a20_r <= r20_i;
    a21_r <= r21_i;
    a22_r <= r22_i;
    neg_r <= neg_nxt;
    neg_o <= neg_r;
    for (int l = 0; l < NUM_LANES; l++) begin
      d_r[l]   <= d_nxt[l];
      rad_r[l] <= rad_nxt[l];
    end
  end

  assign valid_o = v3_r;
  assign rad_o   = rad_r;

endmodule
`default_nettype wire

### src/rmq_sqrt_pipe.sv
// Four-lane pipelined integer square root, one root bit per stage.
`default_nettype none
module rmq_sqrt_pipe #(
  parameter int RAD_W  = 18,
  parameter int SHIFT  = 14,
  parameter int ROOT_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  logic [RAD_W-1:0]   rad_i [rmq_pkg::NUM_LANES],
  input  rmq_pkg::sign_t     neg_i,
  output logic               valid_o,
  output logic [ROOT_W-1:0]  root_o [rmq_pkg::NUM_LANES],
  output rmq_pkg::sign_t     neg_o
);
  import rmq_pkg::*;

  localparam int NPW   = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [NPW-1:0]    n_r   [ROOT_W][NUM_LANES];
  logic [NPW-1:0]    n_nxt [ROOT_W][NUM_LANES];
  logic [REM_W-1:0]  rem_r   [ROOT_W][NUM_LANES];
  logic [REM_W-1:0]  rem_nxt [ROOT_W][NUM_LANES];
  logic [ROOT_W-1:0] q_r   [ROOT_W][NUM_LANES];
  logic [ROOT_W-1:0] q_nxt [ROOT_W][NUM_LANES];
  logic              v_r   [ROOT_W];
  sign_t             neg_r [ROOT_W];

  genvar k, l;
  for (k = 0; k < ROOT_W; k++) begin : g_stage
    for (l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [NPW-1:0]    n_in;
      logic [ROOT_W-1:0] q_in;
      logic [REM_W-1:0]  rem_in, rem_sh, trial;
      if (k == 0) begin : g_first
        assign n_in   = NPW'({rad_i[l], {SHIFT{1'b0}}});
        assign q_in   = '0;
        assign rem_in = '0;
      end else begin : g_next
        assign n_in   = n_r[k-1][l];
        assign q_in   = q_r[k-1][l];
        assign rem_in = rem_r[k-1][l];
      end
      assign rem_sh = {rem_in[REM_W-3:0], n_in[NPW-1 -: 2]};
      assign trial  = REM_W'({q_in, 2'b01});
      assign n_nxt[k][l] = n_in << 2;
      assign rem_nxt[k][l] = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
      assign q_nxt[k][l]   = {q_in[ROOT_W-2:0], (rem_sh >= trial)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_W; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= valid_i;
      for (int i = 1; i < ROOT_W; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    neg_r[0] <= neg_i;
    for (int i = 1; i < ROOT_W; i++) neg_r[i] <= neg_r[i-1];
    for (int i = 0; i < ROOT_W; i++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        n_r[i][j]   <= n_nxt[i][j];
        rem_r[i][j] <= rem_nxt[i][j];
        q_r[i][j]   <= q_nxt[i][j];
      end
    end
  end

  assign valid_o = v_r[ROOT_W-1];
  assign root_o  = q_r[ROOT_W-1];
  assign neg_o   = neg_r[ROOT_W-1];

endmodule
`default_nettype wire

### src/rmq_back.sv
// Back end: halve, saturate, apply signs and register the result.
`default_nettype none
module rmq_back #(
  parameter int FRAC_BITS = 14,
  parameter int ROOT_W    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  logic [ROOT_W-1:0]   root_i [rmq_pkg::NUM_LANES],
  input  rmq_pkg::sign_t      neg_i,
  output logic                valid_o,
  output logic signed [15:0]  qx_o,
  output logic signed [15:0]  qy_o,
  output logic signed [15:0]  qz_o,
  output logic [14:0]         qw_o
);
  import rmq_pkg::*;

  localparam int CW0 = (ROOT_W > FRAC_BITS + 2) ? ROOT_W : FRAC_BITS + 2;
  localparam int CW  = (CW0 > OUT_W) ? CW0 : OUT_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  logic [CW-1:0]    sat [NUM_LANES];
  logic [OUT_W-1:0] mx, my, mz;
  logic             v_r;
  logic [OUT_W-1:0] qx_r, qy_r, qz_r;
  logic [QW_W-1:0]  qw_r;

  always_comb begin
    logic [CW-1:0] m;
    for (int l = 0; l < NUM_LANES; l++) begin
      m = CW'(root_i[l] >> 1);
      sat[l] = (m > ONE_C) ? ONE_C : m;
    end
    mx = sat[LANE_X][OUT_W-1:0];
    my = sat[LANE_Y][OUT_W-1:0];
    mz = sat[LANE_Z][OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else        v_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    qx_r <= neg_i.x_neg ? -mx : mx;
    qy_r <= neg_i.y_neg ? -my : my;
    qz_r <= neg_i.z_neg ? -mz : mz;
    qw_r <= sat[LANE_W][QW_W-1:0];
  end

  assign valid_o = v_r;
  assign qx_o    = qx_r;
  assign qy_o    = qy_r;
  assign qz_o    = qz_r;
  assign qw_o    = qw_r;

endmodule
`default_nettype wire
